// ===== rtl/core/dshot4_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dshot4_pkg;

   localparam int NUM_LANES   = 4;
   localparam int FRAME_BITS  = 16;
   localparam int PW_BITS     = 10;
   localparam int SLOT_BITS   = 5;
   localparam int CSR_IDX_W   = 2;

   // throttle limits
   localparam logic [10:0] THR_MIN = 11'd48;
   localparam logic [10:0] THR_MAX = 11'd2047;

   // checksum keeps one nibble
   localparam logic [3:0] CSUM_MASK = 4'hF;

   // trailing all-zero slot index
   localparam logic [SLOT_BITS-1:0] SLOT_LAST = 5'd16;

   // register reset values
   localparam logic [PW_BITS-1:0] ONE_PW_RESET  = 10'd400;
   localparam logic [PW_BITS-1:0] ZERO_PW_RESET = 10'd200;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ONE_PW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_PW = 2'd1;

   typedef logic [FRAME_BITS-1:0] frame_type;
   typedef logic [PW_BITS-1:0]    pwidth_type;

   // pulse widths handed to the slot stage
   typedef struct packed {
      pwidth_type one_pw;
      pwidth_type zero_pw;
   } pulse_cfg_type;

endpackage

`default_nettype wire

// ===== rtl/core/dshot_four_channel_encoder_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// An input loads the slot stage; its 17 slots go to the output register one
// slot per cycle while the output is not stalled. The next input is accepted
// in the cycle the trailing slot leaves the counter.
// Reset (synchronous, active high) empties the slot stage and output register
// and sets the pulse widths to 400 (one) and 200 (zero).
module dshot_four_channel_encoder_core (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_armed,
   input  wire logic signed [15:0]    req_throttle_a,
   input  wire logic signed [15:0]    req_throttle_b,
   input  wire logic signed [15:0]    req_throttle_c,
   input  wire logic signed [15:0]    req_throttle_d,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [9:0]                 rsp_width_a,
   output logic [9:0]                 rsp_width_b,
   output logic [9:0]                 rsp_width_c,
   output logic [9:0]                 rsp_width_d,
   output logic                       rsp_last_slot,
   input  wire logic                  csr_wr_en,
   input  wire logic [1:0]            csr_index,
   input  wire logic [9:0]            csr_wdata
);

   dshot4_pkg::pulse_cfg_type  cfg_ff, cfg_in;
   dshot4_pkg::frame_type      frames [dshot4_pkg::NUM_LANES];
   dshot4_pkg::pwidth_type     widths [dshot4_pkg::NUM_LANES];
   logic signed [15:0]         throttles [dshot4_pkg::NUM_LANES];
   logic                       load;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            dshot4_pkg::CSR_ONE_PW:  cfg_in.one_pw  = csr_wdata;
            dshot4_pkg::CSR_ZERO_PW: cfg_in.zero_pw = csr_wdata;
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.one_pw  <= dshot4_pkg::ONE_PW_RESET;
         cfg_ff.zero_pw <= dshot4_pkg::ZERO_PW_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign throttles[0] = req_throttle_a;
   assign throttles[1] = req_throttle_b;
   assign throttles[2] = req_throttle_c;
   assign throttles[3] = req_throttle_d;

   // one encoder per channel
   for (genvar g = 0; g < dshot4_pkg::NUM_LANES; g++) begin : g_lane
      dshot4_lane u_lane (
         .armed    (req_armed),
         .throttle (throttles[g]),
         .frame    (frames[g])
      );
   end

   assign load = req_valid && !req_stall;

   dshot4_slot_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .frames     (frames),
      .pulse_cfg  (cfg_ff),
      .busy_stall (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .widths     (widths),
      .last_slot  (rsp_last_slot)
   );

   assign rsp_width_a = widths[0];
   assign rsp_width_b = widths[1];
   assign rsp_width_c = widths[2];
   assign rsp_width_d = widths[3];

endmodule

`default_nettype wire

// ===== rtl/core/dshot4_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none

// One channel: clamp the throttle and build the 16-bit frame with checksum
module dshot4_lane (
   input  wire logic                armed,
   input  wire logic signed [15:0]  throttle,
   output dshot4_pkg::frame_type    frame
);

   logic [10:0] value;
   logic [11:0] word;
   logic [3:0]  csum;

   // saturate to 48..2047, zero when disarmed
   always_comb begin
      if (throttle[15]) begin
         value = dshot4_pkg::THR_MIN;
      end else if (throttle[14:11] != 4'd0) begin
         value = dshot4_pkg::THR_MAX;
      end else if (throttle[10:0] < dshot4_pkg::THR_MIN) begin
         value = dshot4_pkg::THR_MIN;
      end else begin
         value = throttle[10:0];
      end
      if (!armed) begin
         value = 11'd0;
      end
   end

   // telemetry bit is always zero
   assign word  = {value, 1'b0};
   assign csum  = (word[3:0] ^ word[7:4] ^ word[11:8]) & dshot4_pkg::CSUM_MASK;
   assign frame = {word, csum};

endmodule

`default_nettype wire

// ===== rtl/core/dshot4_slot_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Holds the four lane frames, walks the bit slots MSB first and merges the
// lane bits into one registered request of four pulse widths.
module dshot4_slot_merge (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       load,
   input  wire dshot4_pkg::frame_type      frames [dshot4_pkg::NUM_LANES],
   input  wire dshot4_pkg::pulse_cfg_type  pulse_cfg,
   output logic                            busy_stall,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output dshot4_pkg::pwidth_type          widths [dshot4_pkg::NUM_LANES],
   output logic                            last_slot
);

   dshot4_pkg::frame_type          frame_ff [dshot4_pkg::NUM_LANES];
   dshot4_pkg::frame_type          frame_in [dshot4_pkg::NUM_LANES];
   logic [dshot4_pkg::SLOT_BITS-1:0] slot_ff, slot_in;
   logic                           active_ff, active_in;
   logic                           valid_ff, valid_in;
   dshot4_pkg::pwidth_type         width_ff [dshot4_pkg::NUM_LANES];
   dshot4_pkg::pwidth_type         width_in [dshot4_pkg::NUM_LANES];
   logic                           last_ff, last_in;
   logic                           advance;
   logic                           at_last;

   // a slot moves out when the output register is free or being drained
   assign advance    = active_ff && (!valid_ff || !rsp_stall);
   assign at_last    = (slot_ff == dshot4_pkg::SLOT_LAST);
   assign busy_stall = active_ff && !(advance && at_last);

   // slot sequencing and frame shifting
   always_comb begin
      slot_in   = slot_ff;
      active_in = active_ff;
      for (int i = 0; i < dshot4_pkg::NUM_LANES; i++) begin
         frame_in[i] = frame_ff[i];
      end
      if (advance) begin
         if (at_last) begin
            active_in = 1'b0;
         end else begin
            slot_in = slot_ff + 5'd1;
            for (int i = 0; i < dshot4_pkg::NUM_LANES; i++) begin
               frame_in[i] = {frame_ff[i][dshot4_pkg::FRAME_BITS-2:0], 1'b0};
            end
         end
      end
      if (load) begin
         active_in = 1'b1;
         slot_in   = '0;
         for (int i = 0; i < dshot4_pkg::NUM_LANES; i++) begin
            frame_in[i] = frames[i];
         end
      end
   end

   // merge lane bits into the output request
   always_comb begin
      valid_in = valid_ff;
      last_in  = last_ff;
      for (int i = 0; i < dshot4_pkg::NUM_LANES; i++) begin
         width_in[i] = width_ff[i];
      end
      if (advance) begin
         valid_in = 1'b1;
         last_in  = at_last;
         for (int i = 0; i < dshot4_pkg::NUM_LANES; i++) begin
            if (at_last) begin
               width_in[i] = '0;
            end else if (frame_ff[i][dshot4_pkg::FRAME_BITS-1]) begin
               width_in[i] = pulse_cfg.one_pw;
            end else begin
               width_in[i] = pulse_cfg.zero_pw;
            end
         end
      end else if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         valid_ff  <= 1'b0;
         slot_ff   <= '0;
      end else begin
         active_ff <= active_in;
         valid_ff  <= valid_in;
         slot_ff   <= slot_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      last_ff <= last_in;
      for (int i = 0; i < dshot4_pkg::NUM_LANES; i++) begin
         frame_ff[i] <= frame_in[i];
         width_ff[i] <= width_in[i];
      end
   end

   assign rsp_valid = valid_ff;
   assign last_slot = last_ff;
   assign widths    = width_ff;

endmodule

`default_nettype wire

// ===== test/dshot_four_channel_encoder_core_tb.sv =====
`timescale 1ns / 1ps

module dshot_four_channel_encoder_core_tb;

   localparam int RESET_CYCLES    = 7;
   localparam int CYCLE_LIMIT     = 500000;
   localparam int DRAIN_CYCLES    = 20;
   localparam int RANDOM_PHASES   = 6;
   localparam int PRESSURE_AT     = 300;
   localparam int PRESSURE_CYCLES = 500;

   // indexes with no register behind them
   localparam logic [dshot4_pkg::CSR_IDX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [dshot4_pkg::CSR_IDX_W-1:0] CSR_SPARE_3 = 2'd3;

   // frames that can be read straight off the encoding
   localparam dshot4_pkg::frame_type FRAME_ZERO = 16'h0000;   // disarmed
   localparam dshot4_pkg::frame_type FRAME_MIN  = 16'h0606;   // throttle 48
   localparam dshot4_pkg::frame_type FRAME_MAX  = 16'hFFEE;   // throttle 2047

   localparam bit PREDICT = 1'b0;
   localparam bit TYPED   = 1'b1;

   typedef enum int {
      IDLE_SENDER_LIGHT,
      IDLE_SENDER_HEAVY,
      IDLE_NONE
   } idle_mode_type;

   typedef dshot4_pkg::frame_type [0:dshot4_pkg::NUM_LANES-1] lane_frames_type;

   typedef struct packed {
      logic                                   armed;
      logic [0:dshot4_pkg::NUM_LANES-1][15:0] throttle;
   } dshot_req_type;

   typedef struct packed {
      dshot4_pkg::pwidth_type [0:dshot4_pkg::NUM_LANES-1] width;
      logic                                               last;
   } slot_type;

   typedef struct packed {
      dshot_req_type   req;
      logic            typed;
      lane_frames_type frame;
   } stim_row_type;

   logic       clock          = 1'b0;
   logic       reset          = 1'b1;
   logic       req_valid      = 1'b0;
   logic       req_stall;
   logic       req_armed      = 1'b0;
   logic [15:0] req_throttle_a = '0;
   logic [15:0] req_throttle_b = '0;
   logic [15:0] req_throttle_c = '0;
   logic [15:0] req_throttle_d = '0;
   logic       rsp_valid;
   logic       rsp_stall      = 1'b0;
   logic [9:0] rsp_width_a;
   logic [9:0] rsp_width_b;
   logic [9:0] rsp_width_c;
   logic [9:0] rsp_width_d;
   logic       rsp_last_slot;
   logic       csr_wr_en      = 1'b0;
   logic [dshot4_pkg::CSR_IDX_W-1:0] csr_index = '0;
   dshot4_pkg::pwidth_type csr_wdata = '0;

   // shadow of the pulse width registers
   dshot4_pkg::pwidth_type one_pw  = dshot4_pkg::ONE_PW_RESET;
   dshot4_pkg::pwidth_type zero_pw = dshot4_pkg::ZERO_PW_RESET;

   slot_type      slot_queue[$];
   stim_row_type  directed_rows[$];
   int            cycle_count    = 0;
   int            mismatch_count = 0;
   int            slots_seen     = 0;
   logic          hold_on        = 1'b0;
   int            send_idle_pct  = 0;
   int            recv_stall_pct = 0;

   dshot_four_channel_encoder_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_armed      (req_armed),
      .req_throttle_a (req_throttle_a),
      .req_throttle_b (req_throttle_b),
      .req_throttle_c (req_throttle_c),
      .req_throttle_d (req_throttle_d),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_width_a    (rsp_width_a),
      .rsp_width_b    (rsp_width_b),
      .rsp_width_c    (rsp_width_c),
      .rsp_width_d    (rsp_width_d),
      .rsp_last_slot  (rsp_last_slot),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d slots pending", cycle_count,
                  slot_queue.size());
         $display("** dshot_four_channel_encoder_core: FAILED **");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      mismatch_count++;
   endtask

   // clamp, gate on armed, append telemetry bit and nibble checksum
   function automatic dshot4_pkg::frame_type encode_lane(input logic armed,
                                                         input logic [15:0] cmd);
      int          level;
      logic [10:0] value;
      logic [11:0] word;
      level = $signed(cmd);
      if (!armed)
         value = '0;
      else if (level < int'(dshot4_pkg::THR_MIN))
         value = dshot4_pkg::THR_MIN;
      else if (level > int'(dshot4_pkg::THR_MAX))
         value = dshot4_pkg::THR_MAX;
      else
         value = level[10:0];
      word = {value, 1'b0};
      return {word, (word[3:0] ^ word[7:4] ^ word[11:8]) & dshot4_pkg::CSUM_MASK};
   endfunction

   function automatic lane_frames_type encode_request(input dshot_req_type r);
      lane_frames_type f;
      for (int lane = 0; lane < dshot4_pkg::NUM_LANES; lane++)
         f[lane] = encode_lane(r.armed, r.throttle[lane]);
      return f;
   endfunction

   // sixteen bit slots MSB first, then the all-zero trailing slot
   task automatic queue_slots(input lane_frames_type f);
      slot_type s;
      for (int b = dshot4_pkg::FRAME_BITS - 1; b >= 0; b--) begin
         for (int lane = 0; lane < dshot4_pkg::NUM_LANES; lane++)
            s.width[lane] = f[lane][b] ? one_pw : zero_pw;
         s.last = 1'b0;
         slot_queue.push_back(s);
      end
      s.width = '0;
      s.last  = 1'b1;
      slot_queue.push_back(s);
   endtask

   function automatic stim_row_type row(input logic armed, input logic [15:0] a, b, c, d,
                                        input logic typed = PREDICT,
                                        input dshot4_pkg::frame_type fa = FRAME_ZERO,
                                        input dshot4_pkg::frame_type fb = FRAME_ZERO,
                                        input dshot4_pkg::frame_type fc = FRAME_ZERO,
                                        input dshot4_pkg::frame_type fd = FRAME_ZERO);
      stim_row_type r;
      r.req.armed    = armed;
      r.req.throttle = {a, b, c, d};
      r.typed        = typed;
      r.frame        = {fa, fb, fc, fd};
      return r;
   endfunction

   // mostly in-range throttles, some near the clamp points, the rest any 16 bits
   function automatic dshot_req_type random_request();
      dshot_req_type r;
      int            pick;
      r.armed = ($urandom_range(0, 99) < 80);
      for (int lane = 0; lane < dshot4_pkg::NUM_LANES; lane++) begin
         pick = $urandom_range(0, 99);
         if (pick < 50)
            r.throttle[lane] = 16'($urandom_range(48, 2047));
         else if (pick < 58)
            r.throttle[lane] = 16'($urandom_range(44, 52));
         else if (pick < 65)
            r.throttle[lane] = 16'($urandom_range(2043, 2051));
         else
            r.throttle[lane] = 16'($urandom());
      end
      return r;
   endfunction

   // offer one request, hold it until taken, then queue its slots
   task automatic send_request(input dshot_req_type r, input lane_frames_type f);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_armed      <= r.armed;
      req_throttle_a <= r.throttle[0];
      req_throttle_b <= r.throttle[1];
      req_throttle_c <= r.throttle[2];
      req_throttle_d <= r.throttle[3];
      do
         @(posedge clock);
      while (req_stall);
      queue_slots(f);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (slot_queue.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [dshot4_pkg::CSR_IDX_W-1:0] idx,
                            input dshot4_pkg::pwidth_type data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == dshot4_pkg::CSR_ONE_PW)
         one_pw = data;
      else if (idx == dshot4_pkg::CSR_ZERO_PW)
         zero_pw = data;
      @(posedge clock);
   endtask

   // one long hold-off so the encoder backs up into its input
   initial begin : pressure
      wait (slots_seen >= PRESSURE_AT);
      @(posedge clock);
      hold_on <= 1'b1;
      repeat (PRESSURE_CYCLES) @(posedge clock);
      hold_on <= 1'b0;
   end

   // result side: check each slot taken, then decide the next stall
   always @(posedge clock) begin : result_monitor
      slot_type want;
      slot_type got;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got.width = {rsp_width_a, rsp_width_b, rsp_width_c, rsp_width_d};
            got.last  = rsp_last_slot;
            if (slot_queue.size() == 0) begin
               report_mismatch("slot arrived with no request pending");
            end else begin
               want = slot_queue.pop_front();
               for (int lane = 0; lane < dshot4_pkg::NUM_LANES; lane++)
                  if (got.width[lane] !== want.width[lane])
                     report_mismatch($sformatf("lane %0d width %0d, expected %0d",
                                               lane, got.width[lane], want.width[lane]));
               if (got.last !== want.last)
                  report_mismatch($sformatf("last_slot %b, expected %b",
                                            got.last, want.last));
            end
            slots_seen++;
         end
         if (hold_on) begin
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
         end
      end
   end

   initial begin : stimulus
      dshot_req_type          r;
      stim_row_type           d;
      int                     count;
      dshot4_pkg::pwidth_type pw;

      // directed rows: typed frames where the clamp or disarm makes them obvious
      directed_rows.push_back(row(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                  TYPED, FRAME_ZERO, FRAME_ZERO, FRAME_ZERO, FRAME_ZERO));
      directed_rows.push_back(row(1'b0, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001,
                                  TYPED, FRAME_ZERO, FRAME_ZERO, FRAME_ZERO, FRAME_ZERO));
      directed_rows.push_back(row(1'b1, 16'h0030, 16'h0030, 16'h0030, 16'h0030,
                                  TYPED, FRAME_MIN, FRAME_MIN, FRAME_MIN, FRAME_MIN));
      directed_rows.push_back(row(1'b1, 16'h07FF, 16'h07FF, 16'h07FF, 16'h07FF,
                                  TYPED, FRAME_MAX, FRAME_MAX, FRAME_MAX, FRAME_MAX));
      directed_rows.push_back(row(1'b1, 16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF,
                                  TYPED, FRAME_MAX, FRAME_MIN, FRAME_MIN, FRAME_MIN));
      directed_rows.push_back(row(1'b1, 16'h8000, 16'h7FFF, 16'h8001, 16'h7FFE,
                                  TYPED, FRAME_MIN, FRAME_MAX, FRAME_MIN, FRAME_MAX));
      directed_rows.push_back(row(1'b1, 16'h0001, 16'h0002, 16'h002F, 16'h0800,
                                  TYPED, FRAME_MIN, FRAME_MIN, FRAME_MIN, FRAME_MAX));
      directed_rows.push_back(row(1'b1, 16'h0FFF, 16'h5555, 16'hAAAA, 16'h0030,
                                  TYPED, FRAME_MAX, FRAME_MAX, FRAME_MIN, FRAME_MIN));
      directed_rows.push_back(row(1'b0, 16'h0030, 16'h07FF, 16'h03E8, 16'h8000,
                                  TYPED, FRAME_ZERO, FRAME_ZERO, FRAME_ZERO, FRAME_ZERO));
      directed_rows.push_back(row(1'b1, 16'h0031, 16'h07FE, 16'h0400, 16'h03FF));
      directed_rows.push_back(row(1'b1, 16'h03E8, 16'h05DC, 16'h0064, 16'h022B));
      directed_rows.push_back(row(1'b1, 16'h0555, 16'h02AA, 16'h0123, 16'h0789));
      directed_rows.push_back(row(1'b1, 16'h00FF, 16'h0100, 16'h0200, 16'h0700));
      directed_rows.push_back(row(1'b1, 16'h0800, 16'h07FF, 16'h0030, 16'h002F,
                                  TYPED, FRAME_MAX, FRAME_MAX, FRAME_MIN, FRAME_MIN));
      directed_rows.push_back(row(1'b1, 16'h0123, 16'h0456, 16'h0789, 16'h0ABC));
      directed_rows.push_back(row(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                  TYPED, FRAME_ZERO, FRAME_ZERO, FRAME_ZERO, FRAME_ZERO));

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_idle();

         // pulse widths for this phase; the first runs on reset values
         count = 50;
         case (phase)
            0: count = 40;
            1: begin
               write_csr(dshot4_pkg::CSR_ONE_PW, '0);
               write_csr(dshot4_pkg::CSR_ZERO_PW, 10'h3FF);
               write_csr(CSR_SPARE_2, 10'h3FF);
               write_csr(CSR_SPARE_3, 10'h155);
            end
            2: begin
               write_csr(dshot4_pkg::CSR_ONE_PW, 10'h3FF);
               write_csr(dshot4_pkg::CSR_ZERO_PW, '0);
            end
            5: begin
               pw = dshot4_pkg::pwidth_type'($urandom_range(0, 1023));
               write_csr(dshot4_pkg::CSR_ONE_PW, pw);
               write_csr(dshot4_pkg::CSR_ZERO_PW, pw);
               count = 60;
            end
            default: begin
               write_csr(dshot4_pkg::CSR_ONE_PW,
                         dshot4_pkg::pwidth_type'($urandom_range(0, 1023)));
               write_csr(dshot4_pkg::CSR_ZERO_PW,
                         dshot4_pkg::pwidth_type'($urandom_range(0, 1023)));
            end
         endcase

         case (idle_mode_type'(phase % 3))
            IDLE_SENDER_LIGHT: begin
               send_idle_pct  = 18;
               recv_stall_pct = 87;
            end
            IDLE_SENDER_HEAVY: begin
               send_idle_pct  = 87;
               recv_stall_pct = 18;
            end
            default: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
         endcase

         if (phase == 0) begin
            foreach (directed_rows[i]) begin
               d = directed_rows[i];
               send_request(d.req, d.typed ? d.frame : encode_request(d.req));
            end
         end

         repeat (count) begin
            r = random_request();
            send_request(r, encode_request(r));
         end
      end

      wait_idle();
      if (mismatch_count == 0)
         $display("** dshot_four_channel_encoder_core: PASSED **");
      else
         $display("** dshot_four_channel_encoder_core: FAILED **");
      $finish;
   end

endmodule

// ===== dshot_four_channel_encoder_core.f =====
rtl/core/dshot4_pkg.sv
rtl/core/dshot4_lane.sv
rtl/core/dshot4_slot_merge.sv
rtl/core/dshot_four_channel_encoder_core.sv
test/dshot_four_channel_encoder_core_tb.sv
